@@ hw/rtl/prd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prd_pkg;

    localparam int CoordW = 32;
    localparam int RadW   = 31;
    localparam int CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_REP_X    = 3'd0,
        CFG_REP_Y    = 3'd1,
        CFG_REP_Z    = 3'd2,
        CFG_INNER    = 3'd3,
        CFG_OUTER    = 3'd4,
        CFG_STRENGTH = 3'd5
    } t_cfg_idx;

    // per-beat context carried down the pipe
    typedef struct packed {
        logic [2:0][CoordW-1:0] p;
        logic [2:0]             neg;
        logic [2:0][RadW-1:0]   mag;
        logic [RadW-1:0]        len;
        logic                   act;
        logic                   in_zone;
        logic                   eq;
    } t_ctx;

endpackage

`default_nettype wire

@@ hw/rtl/particle_repeller_displacement.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Radial repeller: each beat carries one particle position (signed fixed point x, y, z) and
// returns it pushed away from the repeller position, with a smoothstep falloff between the
// inner and outer radius, saturated to 32 bits, plus a flag that tells whether a push was
// applied. One beat is accepted every clock cycle while the output side is not stalled; the
// result passes through a 32-step pipelined square root, a FRAC_BITS + 1 step falloff divider
// and a 31-step push divider. A stall on the output side freezes the whole pipe; nothing is
// lost or repeated. Configuration writes are for the user to make only once the pipe has
// drained; the block itself does not enforce this.
module particle_repeller_displacement #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [95:0]   s_axis_tdata,   // particle_x, particle_y, particle_z
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [95:0]        m_axis_tdata,   // moved_x, moved_y, moved_z
    output logic               m_axis_tuser    // was_pushed
);

    localparam int TDW   = FRAC_BITS + 1;
    localparam int SQN   = 32;
    localparam int QDN   = 31;
    localparam int ST_E  = 4;
    localparam int SQ0   = 5;
    localparam int ST_F  = SQ0 + SQN;
    localparam int TD0   = ST_F + 1;
    localparam int ST_G  = TD0 + TDW;
    localparam int ST_L  = ST_G + 4;
    localparam int QD0   = ST_L + 1;
    localparam int ST_K  = QD0 + QDN;
    localparam int NST   = ST_K + 1;
    localparam logic [TDW-1:0] ONE_FX = TDW'(1) << FRAC_BITS;

    // configuration
    logic [31:0] r_rep_x, r_rep_y, r_rep_z;
    logic [30:0] r_inner, r_outer, r_strength;
    logic [30:0] r_oe, r_dv;
    logic [61:0] r_oe_sq, r_in_sq;
    logic        r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_x    <= '0;
            r_rep_y    <= '0;
            r_rep_z    <= '0;
            r_inner    <= '0;
            r_outer    <= 31'(50) << FRAC_BITS;
            r_strength <= 31'(50) << FRAC_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prd_pkg::CFG_REP_X:    r_rep_x    <= i_cfg_data;
                prd_pkg::CFG_REP_Y:    r_rep_y    <= i_cfg_data;
                prd_pkg::CFG_REP_Z:    r_rep_z    <= i_cfg_data;
                prd_pkg::CFG_INNER:    r_inner    <= i_cfg_data[30:0];
                prd_pkg::CFG_OUTER:    r_outer    <= i_cfg_data[30:0];
                prd_pkg::CFG_STRENGTH: r_strength <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // derived radius terms, registered from the configuration
    always_ff @(posedge i_clk) begin
        r_oe    <= (r_outer > r_inner) ? r_outer : r_inner;
        r_dv    <= r_oe - r_inner;
        r_oe_sq <= r_oe * r_oe;
        r_in_sq <= r_inner * r_inner;
        r_eq    <= (r_oe == r_inner);
    end

    // pipe control
    logic            w_adv;
    logic [NST-1:0]  r_vld;

    assign w_adv         = !r_vld[ST_K] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vld[ST_K];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // stage a: offsets
    logic [2:0][31:0] r_a_p;
    logic [2:0][32:0] r_a_d;
    logic [2:0][31:0] w_rep;

    assign w_rep = {r_rep_z, r_rep_y, r_rep_x};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_p <= s_axis_tdata;
            for (int k = 0; k < 3; k++) begin
                r_a_d[k] <= {s_axis_tdata[32*k+31], s_axis_tdata[32*k +: 32]}
                          - {w_rep[k][31], w_rep[k]};
            end
        end
    end

    // stage b: magnitudes and far test
    logic [2:0][32:0] n_abs;
    logic             n_far;
    prd_pkg::t_ctx    n_ctx_b;
    prd_pkg::t_ctx    r_ctx [1:ST_K-1];

    always_comb begin
        n_far = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n_abs[k] = r_a_d[k][32] ? (33'd0 - r_a_d[k]) : r_a_d[k];
            if (n_abs[k] > {2'b00, r_oe}) begin
                n_far = 1'b1;
            end
        end
        n_ctx_b        = '0;
        n_ctx_b.p      = r_a_p;
        for (int k = 0; k < 3; k++) begin
            n_ctx_b.neg[k] = r_a_d[k][32];
            n_ctx_b.mag[k] = n_abs[k][30:0];
        end
        n_ctx_b.act    = !n_far;
    end

    // stage c: squares, stage d: sum, stage e: range flags
    logic [2:0][61:0] r_c_sq;
    logic [63:0]      r_d_sum;
    logic [63:0]      r_e_sum;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_c_sq[k] <= r_ctx[1].mag[k] * r_ctx[1].mag[k];
            end
            r_d_sum <= {2'b00, r_c_sq[0]} + {2'b00, r_c_sq[1]} + {2'b00, r_c_sq[2]};
            r_e_sum <= r_d_sum;
        end
    end

    // square root, one result bit per stage
    logic [63:0] r_sq_n    [SQN];
    logic [33:0] r_sq_rem  [SQN];
    logic [31:0] r_sq_root [SQN];

    for (genvar gs = 0; gs < SQN; gs++) begin : g_sq
        localparam int PI = SQN - 1 - gs;
        logic [63:0] w_n;
        logic [33:0] w_rem, w_sh, w_trial;
        logic [31:0] w_root;
        logic        w_ge;
        if (gs == 0) begin : g_first
            assign w_n    = r_e_sum;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_n    = r_sq_n[gs-1];
            assign w_rem  = r_sq_rem[gs-1];
            assign w_root = r_sq_root[gs-1];
        end
        assign w_sh    = {w_rem[31:0], w_n[2*PI+1 -: 2]};
        assign w_trial = {w_root, 2'b01};
        assign w_ge    = (w_sh >= w_trial);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_n[gs]    <= w_n;
                r_sq_rem[gs]  <= w_ge ? (w_sh - w_trial) : w_sh;
                r_sq_root[gs] <= {w_root[30:0], w_ge};
            end
        end
    end

    // context shift
    prd_pkg::t_ctx n_ctx_e, n_ctx_f;

    always_comb begin
        n_ctx_e         = r_ctx[ST_E-1];
        n_ctx_e.act     = r_ctx[ST_E-1].act && (r_d_sum != 64'd0)
                          && (r_d_sum <= {2'b00, r_oe_sq});
        n_ctx_e.in_zone = (r_d_sum < {2'b00, r_in_sq});
        n_ctx_e.eq      = r_eq;
        n_ctx_f         = r_ctx[ST_F-1];
        n_ctx_f.len     = r_sq_root[SQN-1][30:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ctx[1] <= n_ctx_b;
            for (int s = 2; s < ST_K; s++) begin
                if (s == ST_E) begin
                    r_ctx[s] <= n_ctx_e;
                end else if (s == ST_F) begin
                    r_ctx[s] <= n_ctx_f;
                end else begin
                    r_ctx[s] <= r_ctx[s-1];
                end
            end
        end
    end

    // stage f: falloff numerator
    logic [31:0] r_f_rem;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_rem <= {1'b0, r_sq_root[SQN-1][30:0]} - {1'b0, r_inner};
        end
    end

    // falloff divider, one quotient bit per stage
    logic [31:0]    r_td_rem [TDW];
    logic [TDW-1:0] r_td_q   [TDW];

    for (genvar gt = 0; gt < TDW; gt++) begin : g_td
        logic [31:0]    w_sh, w_diff;
        logic [TDW-1:0] w_q;
        logic           w_ge;
        if (gt == 0) begin : g_first
            assign w_sh = r_f_rem;
            assign w_q  = '0;
        end else begin : g_next
            assign w_sh = {r_td_rem[gt-1][30:0], 1'b0};
            assign w_q  = r_td_q[gt-1];
        end
        assign w_diff = w_sh - {1'b0, r_dv};
        assign w_ge   = (w_sh >= {1'b0, r_dv});
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_td_rem[gt] <= w_ge ? w_diff : w_sh;
                r_td_q[gt]   <= {w_q[TDW-2:0], w_ge};
            end
        end
    end

    // smoothstep and push magnitude
    logic [TDW-1:0]       n_t;
    logic [2*TDW-1:0]     n_tt;
    logic [TDW-1:0]       r_g_t, r_g_t2;
    logic [TDW:0]         n_k;
    logic [2*TDW:0]       n_sp;
    logic [FRAC_BITS+2:0] n_shi;
    logic [TDW-1:0]       r_h_s, r_i_fac;
    logic [30+TDW:0]      n_up;
    logic [30:0]          r_j_u;
    logic [2:0][61:0]     r_l_prod;

    always_comb begin
        n_t   = (r_td_q[TDW-1] > ONE_FX) ? ONE_FX : r_td_q[TDW-1];
        n_tt  = n_t * n_t;
        n_k   = {ONE_FX, 1'b0} + {1'b0, ONE_FX} - {r_g_t, 1'b0};
        n_sp  = r_g_t2 * n_k;
        n_shi = n_sp[2*TDW:FRAC_BITS];
        n_up  = r_strength * r_i_fac;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g_t  <= n_t;
            r_g_t2 <= n_tt[FRAC_BITS +: TDW];
            r_h_s  <= (n_shi > (FRAC_BITS+3)'(ONE_FX)) ? ONE_FX : n_shi[TDW-1:0];
            if (r_ctx[ST_G+1].in_zone) begin
                r_i_fac <= ONE_FX;
            end else if (r_ctx[ST_G+1].eq) begin
                r_i_fac <= '0;
            end else begin
                r_i_fac <= ONE_FX - r_h_s;
            end
            r_j_u  <= n_up[FRAC_BITS +: 31];
            for (int k = 0; k < 3; k++) begin
                r_l_prod[k] <= r_ctx[ST_L-1].mag[k] * r_j_u;
            end
        end
    end

    // push divider, three lanes, one quotient bit per stage
    logic [2:0][61:0] r_qd_prod [QDN];
    logic [2:0][30:0] r_qd_rem  [QDN];
    logic [2:0][30:0] r_qd_q    [QDN];

    for (genvar gq = 0; gq < QDN; gq++) begin : g_qd
        localparam int PB = QDN - 1 - gq;
        logic [2:0][61:0] w_prod;
        logic [2:0][30:0] w_rem, w_q;
        logic [2:0][31:0] w_sh, w_diff;
        logic [2:0][30:0] w_rem_n, w_q_n;
        logic [31:0]      w_len;
        if (gq == 0) begin : g_first
            assign w_prod = r_l_prod;
            assign w_q    = '0;
            for (genvar gk = 0; gk < 3; gk++) begin : g_init
                assign w_rem[gk] = r_l_prod[gk][61:31];
            end
        end else begin : g_next
            assign w_prod = r_qd_prod[gq-1];
            assign w_rem  = r_qd_rem[gq-1];
            assign w_q    = r_qd_q[gq-1];
        end
        assign w_len = {1'b0, r_ctx[QD0+gq-1].len};
        for (genvar gk = 0; gk < 3; gk++) begin : g_lane
            assign w_sh[gk]    = {w_rem[gk], w_prod[gk][PB]};
            assign w_diff[gk]  = w_sh[gk] - w_len;
            assign w_rem_n[gk] = (w_sh[gk] >= w_len) ? w_diff[gk][30:0] : w_sh[gk][30:0];
            assign w_q_n[gk]   = {w_q[gk][29:0], (w_sh[gk] >= w_len)};
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_qd_prod[gq] <= w_prod;
                r_qd_rem[gq]  <= w_rem_n;
                r_qd_q[gq]    <= w_q_n;
            end
        end
    end

    // stage k: apply push and saturate
    prd_pkg::t_ctx    w_ctx_k;
    logic [2:0][32:0] n_push;
    logic [2:0][33:0] n_sum;
    logic [95:0]      n_out;
    logic             n_pushed;
    logic [95:0]      r_out_data;
    logic             r_out_user;

    assign w_ctx_k = r_ctx[ST_K-1];

    always_comb begin
        n_pushed = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (!w_ctx_k.act) begin
                n_push[k] = '0;
            end else if (w_ctx_k.neg[k]) begin
                n_push[k] = 33'd0 - {2'b00, r_qd_q[QDN-1][k]};
            end else begin
                n_push[k] = {2'b00, r_qd_q[QDN-1][k]};
            end
            if (w_ctx_k.act && (r_qd_q[QDN-1][k] != 31'd0)) begin
                n_pushed = 1'b1;
            end
            n_sum[k] = {{2{w_ctx_k.p[k][31]}}, w_ctx_k.p[k]} + {n_push[k][32], n_push[k]};
            if (!n_sum[k][33] && (n_sum[k][32:31] != 2'b00)) begin
                n_out[32*k +: 32] = 32'h7FFF_FFFF;
            end else if (n_sum[k][33] && (n_sum[k][32:31] != 2'b11)) begin
                n_out[32*k +: 32] = 32'h8000_0000;
            end else begin
                n_out[32*k +: 32] = n_sum[k][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out;
            r_out_user <= n_pushed;
        end
    end

    assign m_axis_tdata = r_out_data;
    assign m_axis_tuser = r_out_user;

    // checks
    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_F-1] |-> (r_sq_rem[SQN-1] <= {1'b0, r_sq_root[SQN-1], 1'b0}))
        else $error("square root remainder out of range");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_G-1] && r_ctx[ST_G-1].act && !r_ctx[ST_G-1].in_zone && !r_ctx[ST_G-1].eq)
        |-> (r_td_q[TDW-1] <= ONE_FX))
        else $error("falloff ratio above one");

    a_qd_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_K-1] && w_ctx_k.act) |-> ({1'b0, r_qd_rem[QDN-1][0]} < {1'b0, w_ctx_k.len}))
        else $error("push divider remainder not below length");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
